// ----- sv/mq_pkg.sv -----
// ----------------------------------------------------------------------------
// mq_pkg: shared types and constants of the quickselect median block
// Sample type, field widths and command codes used by the interfaces and RTL.
// ----------------------------------------------------------------------------
package mq_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SIZE_W   = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SIZE_W-1:0]   t_size;

    // command field codes
    localparam logic CMD_APPEND  = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

endpackage

// ----- sv/mq_if.sv -----
// ----------------------------------------------------------------------------
// mq_if: valid/ready channels of the quickselect median block
// Input channel carries a command and a sample, output channel the result.
// ----------------------------------------------------------------------------
interface mq_in_if;
    logic             valid;
    logic             ready;
    logic             command;
    mq_pkg::t_sample  sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

interface mq_out_if;
    logic             valid;
    logic             ready;
    mq_pkg::t_sample  median;
    mq_pkg::t_size    set_size;
    logic             overflowed;

    modport source (output valid, output median, output set_size, output overflowed,
                    input ready);
    modport sink   (input valid, input median, input set_size, input overflowed,
                    output ready);
endinterface

// ----- sv/mq_store.sv -----
// ----------------------------------------------------------------------------
// mq_store: sample memory
// One write port, one read port with a registered read word.
// ----------------------------------------------------------------------------
module mq_store #(
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output mq_pkg::t_sample o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  mq_pkg::t_sample i_wr_data
);

    mq_pkg::t_sample r_mem [DEPTH];
    mq_pkg::t_sample r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, word held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/mq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mq_ctrl: load and selection sequencer
// Appends samples to the store and runs the Lomuto quickselect over it.
// ----------------------------------------------------------------------------
module mq_ctrl #(
    parameter int  CAPACITY = 1024,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mq_in_if.sink           i_in,
    mq_out_if.source        o_out,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  mq_pkg::t_sample i_rd_data,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output mq_pkg::t_sample o_wr_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PIV_RD  = 4'd1;
    localparam logic [3:0] ST_PIV     = 4'd2;
    localparam logic [3:0] ST_CMP     = 4'd3;
    localparam logic [3:0] ST_SWP1    = 4'd4;
    localparam logic [3:0] ST_SWP2    = 4'd5;
    localparam logic [3:0] ST_FIN_RD  = 4'd6;
    localparam logic [3:0] ST_FIN_WR1 = 4'd7;
    localparam logic [3:0] ST_FIN_WR2 = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]      r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [CW-1:0]   r_size;
    logic            r_ovf_snap;
    logic [AW-1:0]   r_lo;
    logic [AW-1:0]   r_hi;
    logic [AW-1:0]   r_i;
    logic [AW-1:0]   r_p;
    logic [CW-1:0]   r_k;
    mq_pkg::t_sample r_pv;
    mq_pkg::t_sample r_vi;
    logic            r_out_valid;
    mq_pkg::t_sample r_median;
    mq_pkg::t_size   r_out_size;
    logic            r_out_ovf;

    logic            in_acc;
    logic            is_less;
    logic            scan_end;
    logic            slot_free;
    logic [AW-1:0]   i_inc;
    logic [AW-1:0]   p_inc;
    logic [CW-1:0]   rank;
    logic [CW:0]     k_init;

    assign in_acc    = i_in.valid && i_in.ready;
    assign is_less   = i_rd_data < r_pv;
    assign scan_end  = (r_i == r_hi);
    assign slot_free = !r_out_valid || o_out.ready;
    assign i_inc     = r_i + AW'(1);
    assign p_inc     = r_p + AW'(1);
    assign rank      = CW'(r_p) - CW'(r_lo) + CW'(1);
    assign k_init    = ({1'b0, r_count} + (CW+1)'(1)) >> 1;

    assign i_in.ready       = i_rst_n && (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.median     = r_median;
    assign o_out.set_size   = r_out_size;
    assign o_out.overflowed = r_out_ovf;

    // memory port control
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_lo;
        o_wr_en   = 1'b0;
        o_wr_addr = r_p;
        o_wr_data = r_pv;
        case (r_state)
            ST_IDLE: begin
                o_wr_addr = r_count[AW-1:0];
                o_wr_data = i_in.sample;
                o_wr_en   = in_acc && (i_in.command == mq_pkg::CMD_APPEND) &&
                            (r_count < CW'(CAPACITY));
            end
            ST_PIV_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_lo;
            end
            ST_PIV: begin
                o_rd_en   = (r_lo != r_hi);
                o_rd_addr = r_lo + AW'(1);
            end
            ST_CMP: begin
                if (is_less) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = p_inc;
                end else begin
                    o_rd_en   = !scan_end;
                    o_rd_addr = i_inc;
                end
            end
            ST_SWP1: begin
                // store[p] <= scanned word; store[p] old word stays in the read reg
                o_wr_en   = 1'b1;
                o_wr_addr = r_p;
                o_wr_data = r_vi;
            end
            ST_SWP2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_i;
                o_wr_data = i_rd_data;
                o_rd_en   = !scan_end;
                o_rd_addr = i_inc;
            end
            ST_FIN_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_p;
            end
            ST_FIN_WR1: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_lo;
                o_wr_data = i_rd_data;
            end
            ST_FIN_WR2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_p;
                o_wr_data = r_pv;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; ST_DONE reloads the slot itself
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.command == mq_pkg::CMD_APPEND) begin
                            if (r_count < CW'(CAPACITY)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else begin
                            // snapshot the set, then clear it for the next one
                            r_size     <= r_count;
                            r_ovf_snap <= r_ovf;
                            r_count    <= '0;
                            r_ovf      <= 1'b0;
                            r_lo       <= '0;
                            r_hi       <= AW'(r_count - CW'(1));
                            r_k        <= k_init[CW-1:0];
                            if (r_count == '0) begin
                                r_pv    <= '0;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_PIV_RD;
                            end
                        end
                    end
                end
                ST_PIV_RD: begin
                    r_state <= ST_PIV;
                end
                ST_PIV: begin
                    r_pv <= i_rd_data;
                    r_p  <= r_lo;
                    r_i  <= r_lo + AW'(1);
                    // single-entry range: its only word is the answer
                    r_state <= (r_lo == r_hi) ? ST_DONE : ST_CMP;
                end
                ST_CMP: begin
                    if (is_less) begin
                        r_p     <= p_inc;
                        r_vi    <= i_rd_data;
                        r_state <= ST_SWP1;
                    end else if (scan_end) begin
                        r_state <= ST_FIN_RD;
                    end else begin
                        r_i <= i_inc;
                    end
                end
                ST_SWP1: begin
                    r_state <= ST_SWP2;
                end
                ST_SWP2: begin
                    if (scan_end) begin
                        r_state <= ST_FIN_RD;
                    end else begin
                        r_i     <= i_inc;
                        r_state <= ST_CMP;
                    end
                end
                ST_FIN_RD: begin
                    r_state <= ST_FIN_WR1;
                end
                ST_FIN_WR1: begin
                    r_state <= ST_FIN_WR2;
                end
                ST_FIN_WR2: begin
                    // pivot now sits at p; narrow to the side holding rank k
                    if (rank == r_k) begin
                        r_state <= ST_DONE;
                    end else begin
                        if (rank > r_k) begin
                            r_hi <= r_p - AW'(1);
                        end else begin
                            r_k  <= r_k - rank;
                            r_lo <= p_inc;
                        end
                        r_state <= ST_PIV_RD;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && slot_free) begin
            r_median   <= r_pv;
            r_out_size <= mq_pkg::SIZE_W'(r_size);
            r_out_ovf  <= r_ovf_snap;
        end
    end

endmodule

// ----- sv/median_quickselect.sv -----
// ----------------------------------------------------------------------------
// median_quickselect: lower median of a loaded sample set by quickselect
// Samples are appended to an on-chip store; a compute command selects the
// ((n+1)/2)-th smallest by in-place Lomuto partitioning.
//
//   channel  dir  words                        handshake
//   i_in     in   command, sample              valid/ready
//   o_out    out  median, set_size, overflowed valid/ready
//
// Appends stream back to back, also while a result word waits on o_out. A
// compute runs partition rounds (read the pivot, scan the range with a swap
// per smaller word, move the pivot into place), then loads the result word;
// all store traffic goes through the single read and single write port of
// the sample memory. Reset clears the count and the overflow flag; the store
// needs no clearing. Input ready is low during a compute and while its
// result waits for the output slot.
// ----------------------------------------------------------------------------
module median_quickselect #(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mq_in_if.sink     i_in,
    mq_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    mq_pkg::t_sample rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    mq_pkg::t_sample wr_data;

    // sequencer
    mq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // sample memory
    mq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // no read and write of the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("store read and write hit the same entry");

    // writes stay inside the store
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < 32'(CAPACITY)))
        else $error("store write beyond capacity");

    // a compute word closes the input until its result word is loaded into the output slot
    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.command == mq_pkg::CMD_COMPUTE))
        |=> !i_in.ready)
        else $error("input still ready after compute word");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the quickselect median block
// Streams sample sets and compute commands into the block through random
// gaps and output stalls. A local model of the block tracks the loaded set,
// performs the same in-place partition search and queues one expected
// median per compute. Every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CAPACITY   = 1024;
    localparam int              HOLD_CYC   = 400;
    localparam int              DRAIN_CYC  = 50;
    localparam mq_pkg::t_sample SMP_MIN    = 32'sh8000_0000;
    localparam mq_pkg::t_sample SMP_MAX    = 32'sh7FFF_FFFF;

    // how the samples of one generated set are picked
    typedef enum int {
        FILL_SPREAD,
        FILL_NARROW,
        FILL_RISING,
        FILL_FALLING,
        FILL_EXTREME
    } t_fill;

    // one input word waiting to be driven
    typedef struct {
        logic            command;
        mq_pkg::t_sample sample;
        bit              drain;     // hold this word until no result is outstanding
        bit              burst;     // no gap after this word
    } t_in_word;

    typedef struct {
        mq_pkg::t_sample median;
        mq_pkg::t_size   set_size;
        logic            overflowed;
    } t_median_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mq_in_if  in_if ();
    mq_out_if out_if ();

    median_quickselect #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_in_word       pending_words[$];
    t_median_result expected_medians[$];

    // shadow of the block's store and set bookkeeping
    mq_pkg::t_sample store_copy[CAPACITY];
    int              count_copy;
    logic            overflow_copy;

    int words_queued;
    int gap_left;
    bit cur_burst;
    int stall_left;
    int hold_left;
    int results_seen;
    int mismatches;

    // ------------------------------------------------------------------------
    // Lower median of the shadow set by quickselect, Lomuto partition around
    // the first entry of the range; reorders store_copy the same way.
    // ------------------------------------------------------------------------
    function automatic mq_pkg::t_sample select_lower_median();
        int              lo;
        int              hi;
        int              k;
        int              p;
        int              rank;
        mq_pkg::t_sample pivot;
        mq_pkg::t_sample tmp;
        mq_pkg::t_sample found;
        bit              done;
        lo    = 0;
        hi    = count_copy - 1;
        k     = (count_copy + 1) / 2;
        done  = 1'b0;
        found = '0;
        while (!done) begin
            pivot = store_copy[lo];
            p     = lo;
            for (int i = lo + 1; i <= hi; i++) begin
                if (store_copy[i] < pivot) begin
                    p++;
                    tmp           = store_copy[p];
                    store_copy[p] = store_copy[i];
                    store_copy[i] = tmp;
                end
            end
            tmp            = store_copy[lo];
            store_copy[lo] = store_copy[p];
            store_copy[p]  = tmp;
            rank = p - lo + 1;
            if (rank == k) begin
                found = store_copy[p];
                done  = 1'b1;
            end else if (rank > k) begin
                hi = p - 1;
            end else begin
                k  = k - rank;
                lo = p + 1;
            end
        end
        return found;
    endfunction

    // Update the shadow state with one accepted word; computes queue a result.
    function automatic void apply_word(input logic cmd, input mq_pkg::t_sample smp);
        t_median_result res;
        if (cmd == mq_pkg::CMD_APPEND) begin
            if (count_copy < CAPACITY) begin
                store_copy[count_copy] = smp;
                count_copy++;
            end else begin
                overflow_copy = 1'b1;
            end
        end else begin
            res.median     = (count_copy > 0) ? select_lower_median() : '0;
            res.set_size   = mq_pkg::t_size'(count_copy);
            res.overflowed = overflow_copy;
            expected_medians.push_back(res);
            count_copy    = 0;
            overflow_copy = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic cmd, input mq_pkg::t_sample smp,
                              input bit drain, input bit burst);
        t_in_word w;
        w.command = cmd;
        w.sample  = smp;
        w.drain   = drain;
        w.burst   = burst;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_append(input mq_pkg::t_sample smp);
        queue_word(mq_pkg::CMD_APPEND, smp, 1'b0, 1'b0);
    endtask

    // the sample field is don't-care on a compute, so it carries noise
    task automatic queue_compute(input bit drain);
        queue_word(mq_pkg::CMD_COMPUTE, mq_pkg::t_sample'($urandom), drain, 1'b0);
    endtask

    task automatic load_set(input int size, input t_fill fill, input bit drain,
                            input bit burst);
        int              base;
        int              step;
        mq_pkg::t_sample smp;
        base = int'($urandom_range(0, 2000)) - 1000;
        step = $urandom_range(0, 3);
        for (int i = 0; i < size; i++) begin
            case (fill)
                FILL_NARROW:  smp = mq_pkg::t_sample'(int'($urandom_range(0, 8)) - 4);
                FILL_RISING:  smp = mq_pkg::t_sample'(base + i * step);
                FILL_FALLING: smp = mq_pkg::t_sample'(base - i * step);
                FILL_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       smp = SMP_MIN;
                        1:       smp = SMP_MAX;
                        2:       smp = '0;
                        default: smp = -1;
                    endcase
                end
                default:      smp = mq_pkg::t_sample'($urandom);
            endcase
            queue_word(mq_pkg::CMD_APPEND, smp, drain && (i == 0), burst);
        end
        queue_word(mq_pkg::CMD_COMPUTE, mq_pkg::t_sample'($urandom),
                   drain && (size == 0), burst);
    endtask

    // mostly short sets; sorted and duplicate-heavy fills stay short since
    // they drive the partition search to its worst case
    task automatic add_random_set();
        int    sel;
        int    size;
        t_fill fill;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            size = 0;
        end else if (sel == 1) begin
            size = $urandom_range(25, 120);
        end else begin
            size = $urandom_range(1, 24);
        end
        fill = (size > 24) ? FILL_SPREAD : t_fill'($urandom_range(0, 4));
        load_set(size, fill, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued words, random gap after each accepted word unless it is a burst word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_in_word nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                apply_word(in_if.command, in_if.sample);
                gap_left = cur_burst ? 0 : $urandom_range(0, 3);
            end
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain && expected_medians.size() > 0)) begin
                nxt = pending_words.pop_front();
                in_if.valid   <= 1'b1;
                in_if.command <= nxt.command;
                in_if.sample  <= nxt.sample;
                cur_burst = nxt.burst;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result word, random stalls plus two long hold-offs
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_median_result exp_res;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_medians.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word: median %0d size %0d ovf %0b",
                                 $realtime, out_if.median, out_if.set_size,
                                 out_if.overflowed);
                end else begin
                    exp_res = expected_medians.pop_front();
                    if (out_if.median !== exp_res.median ||
                        out_if.set_size !== exp_res.set_size ||
                        out_if.overflowed !== exp_res.overflowed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d: expected median %0d size %0d ovf %0b,",
                                     $realtime, results_seen, exp_res.median,
                                     exp_res.set_size, exp_res.overflowed,
                                     " got median %0d size %0d ovf %0b", out_if.median,
                                     out_if.set_size, out_if.overflowed);
                    end
                end
                // long hold-offs let the next result back up into the input
                if (results_seen == 6 || results_seen == 25) begin
                    hold_left = HOLD_CYC;
                end else begin
                    stall_left = ((results_seen / 8) % 3 == 0) ? 0 : $urandom_range(0, 3);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of test
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.command  = mq_pkg::CMD_APPEND;
        in_if.sample   = '0;
        out_if.ready   = 1'b0;
        count_copy     = 0;
        overflow_copy  = 1'b0;
        words_queued   = 0;
        results_seen   = 0;
        mismatches     = 0;
        cur_burst      = 1'b0;

        // directed: empty set, single extremes, even and odd sizes,
        // duplicates, reverse order
        queue_compute(1'b0);
        queue_append(SMP_MIN);
        queue_compute(1'b0);
        queue_append(SMP_MAX);
        queue_compute(1'b1);
        queue_append(SMP_MAX);
        queue_append(SMP_MIN);
        queue_compute(1'b0);
        queue_append(-1);
        queue_append(0);
        queue_append(1);
        queue_compute(1'b0);
        queue_append(5);
        queue_append(5);
        queue_append(5);
        queue_compute(1'b1);
        queue_append(4);
        queue_append(3);
        queue_append(2);
        queue_append(1);
        queue_compute(1'b0);

        // random sets, one overfilled store in the middle
        while (words_queued < 600)
            add_random_set();
        load_set(CAPACITY + 3, FILL_SPREAD, 1'b1, 1'b0);
        while (words_queued < 1750)
            add_random_set();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_if.valid)
            @(posedge i_clk);
        while (expected_medians.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mq_pkg.sv
sv/mq_if.sv
sv/mq_store.sv
sv/mq_ctrl.sv
sv/median_quickselect.sv
verif/tb_top.sv
